[sv/psad_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Program stream audio demux: shared package
// Parse phases, protocol byte values and the result beat type shared by the
// parser, the result queue and the top level.
// ----------------------------------------------------------------------------
package psad_pkg;

	// Depth of the queue between the parser and the output side.
	localparam int QUEUE_DEPTH = 4;

	// Start code ids and the pack header length after its id byte.
	localparam logic [7:0] PACK_ID   = 8'hBA;
	localparam logic [7:0] END_ID    = 8'hB9;
	localparam logic [7:0] AUDIO_LO  = 8'hC0;
	localparam logic [7:0] AUDIO_HI  = 8'hDF;
	localparam logic [3:0] PACK_REST = 4'd8;

	// Audio packet header bytes.
	localparam logic [7:0] STUFF_BYTE = 8'hFF;
	localparam logic [7:0] STD_MASK   = 8'hC0;
	localparam logic [7:0] STD_TAG    = 8'h40;
	localparam logic [7:0] TS_MASK    = 8'hF0;
	localparam logic [7:0] TS_PTS     = 8'h20;
	localparam logic [7:0] TS_PTS_DTS = 8'h30;
	localparam logic [7:0] TS_NONE    = 8'h0F;
	localparam logic [3:0] PTS_REST     = 4'd4;
	localparam logic [3:0] PTS_DTS_REST = 4'd9;

	typedef enum logic [3:0] {
		PH_SEARCH,
		PH_ID,
		PH_PACK,
		PH_LHI_O,
		PH_LLO_O,
		PH_LHI_A,
		PH_LLO_A,
		PH_SKIP,
		PH_STUFF,
		PH_STD,
		PH_TS,
		PH_FSKIP,
		PH_PAYLOAD,
		PH_ENDED
	} phase_t;

	typedef struct packed {
		logic [7:0] es_byte;
		logic       byte_valid;
		logic       end_of_stream;
		logic [7:0] audio_stream_id;
	} result_t;

endpackage
`default_nettype wire

[sv/program_stream_audio_demux_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Program stream audio demux core
// Extracts the payload of the first audio stream of an MPEG-1 program stream.
// ----------------------------------------------------------------------------
// Usage:
// The source channel (src_valid / src_ready) carries one stream byte per beat
// with end_of_input set on the final byte. The result channel
// (res_valid / res_ready) carries one beat for every audio payload byte and
// one for the final byte, which has end_of_stream set and byte_valid set only
// if that byte is payload too. audio_stream_id shows the locked audio id, or
// zero until the first audio packet length has been read.
// The parser takes one byte per cycle while the queue has room; a result beat
// is written into the queue when the byte that caused it is taken. Sustained
// throughput is one byte per cycle while the receiver keeps up.
// Results wait in a queue of QUEUE_DEPTH beats. When the receiver stalls the
// queue fills and src_ready drops only once it is full, so the parser and the
// receiver stall independently of each other.
// After the final byte the parser is back in its reset state and the next
// stream may follow at once. Reset clears the parser and empties the queue.
// ----------------------------------------------------------------------------
module program_stream_audio_demux_core #(
	parameter int QUEUE_DEPTH = psad_pkg::QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       src_valid,
	output logic            src_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_input,
	output logic            res_valid,
	input  wire logic       res_ready,
	output logic [7:0]      es_byte,
	output logic            byte_valid,
	output logic            end_of_stream,
	output logic [7:0]      audio_stream_id
);

	logic              accept;
	logic              push;
	logic              full;
	psad_pkg::result_t parsed;
	psad_pkg::result_t head;

	// A byte is taken whenever the queue has room for its possible result.
	assign src_ready = !full;
	assign accept    = src_valid && src_ready;

	psad_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (accept),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.push         (push),
		.result       (parsed)
	);

	psad_queue #(
		.Depth (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (parsed),
		.full       (full),
		.head_valid (res_valid),
		.pop        (res_ready),
		.head       (head)
	);

	assign es_byte         = head.es_byte;
	assign byte_valid      = head.byte_valid;
	assign end_of_stream   = head.end_of_stream;
	assign audio_stream_id = head.audio_stream_id;

endmodule
`default_nettype wire

[sv/psad_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Program stream audio demux: stream parser
// Classifies each accepted byte, tracks start codes and packet lengths, and
// produces a result beat for payload bytes and for the final byte.
// ----------------------------------------------------------------------------
module psad_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        in_byte,
	input  wire logic              end_of_input,
	output logic                   push,
	output psad_pkg::result_t      result
);

	psad_pkg::phase_t phase_q, phase_d;
	logic [1:0]  zero_run_q, zero_run_d;
	logic [3:0]  header_count_q, header_count_d;
	logic [7:0]  length_high_q, length_high_d;
	logic [15:0] remaining_q, remaining_d;
	logic [3:0]  field_skip_q, field_skip_d;
	logic [7:0]  locked_id_q, locked_id_d;
	logic        id_locked_q, id_locked_d;
	logic        emit;

	// Next state.
	always_comb begin
		logic        in_packet;
		logic [15:0] len;
		in_packet      = 1'b0;
		len            = {length_high_q, in_byte};
		phase_d        = phase_q;
		zero_run_d     = zero_run_q;
		header_count_d = header_count_q;
		length_high_d  = length_high_q;
		remaining_d    = remaining_q;
		field_skip_d   = field_skip_q;
		locked_id_d    = locked_id_q;
		id_locked_d    = id_locked_q;

		case (phase_q)
			psad_pkg::PH_SEARCH: begin
				if (in_byte == 8'h00) begin
					if (zero_run_q != 2'd2) zero_run_d = zero_run_q + 2'd1;
				end else if (in_byte == 8'h01 && zero_run_q == 2'd2) begin
					zero_run_d = 2'd0;
					phase_d    = psad_pkg::PH_ID;
				end else begin
					zero_run_d = 2'd0;
				end
			end
			psad_pkg::PH_ID: begin
				if (in_byte == psad_pkg::PACK_ID) begin
					header_count_d = psad_pkg::PACK_REST;
					phase_d        = psad_pkg::PH_PACK;
				end else if (in_byte == psad_pkg::END_ID) begin
					phase_d = psad_pkg::PH_ENDED;
				end else if (in_byte inside {[psad_pkg::AUDIO_LO:psad_pkg::AUDIO_HI]} &&
				             (!id_locked_q || in_byte == locked_id_q)) begin
					locked_id_d = in_byte;
					phase_d     = psad_pkg::PH_LHI_A;
				end else begin
					phase_d = psad_pkg::PH_LHI_O;
				end
			end
			psad_pkg::PH_PACK: begin
				if (header_count_q != 4'd0) header_count_d = header_count_q - 4'd1;
				if (header_count_q <= 4'd1) begin
					zero_run_d = 2'd0;
					phase_d    = psad_pkg::PH_SEARCH;
				end
			end
			psad_pkg::PH_LHI_O: begin
				length_high_d = in_byte;
				phase_d       = psad_pkg::PH_LLO_O;
			end
			psad_pkg::PH_LHI_A: begin
				length_high_d = in_byte;
				phase_d       = psad_pkg::PH_LLO_A;
			end
			psad_pkg::PH_LLO_O, psad_pkg::PH_LLO_A: begin
				remaining_d = len;
				if (phase_q == psad_pkg::PH_LLO_A) begin
					id_locked_d = 1'b1;
					phase_d     = psad_pkg::PH_STUFF;
				end else begin
					phase_d = psad_pkg::PH_SKIP;
				end
				if (len == 16'd0) begin
					zero_run_d = 2'd0;
					phase_d    = psad_pkg::PH_SEARCH;
				end
			end
			psad_pkg::PH_SKIP: begin
				in_packet = 1'b1;
			end
			psad_pkg::PH_STUFF, psad_pkg::PH_TS: begin
				in_packet = 1'b1;
				if (phase_q == psad_pkg::PH_STUFF && in_byte == psad_pkg::STUFF_BYTE) begin
					phase_d = psad_pkg::PH_STUFF;
				end else if (phase_q == psad_pkg::PH_STUFF &&
				             (in_byte & psad_pkg::STD_MASK) == psad_pkg::STD_TAG) begin
					phase_d = psad_pkg::PH_STD;
				end else if ((in_byte & psad_pkg::TS_MASK) == psad_pkg::TS_PTS) begin
					field_skip_d = psad_pkg::PTS_REST;
					phase_d      = psad_pkg::PH_FSKIP;
				end else if ((in_byte & psad_pkg::TS_MASK) == psad_pkg::TS_PTS_DTS) begin
					field_skip_d = psad_pkg::PTS_DTS_REST;
					phase_d      = psad_pkg::PH_FSKIP;
				end else begin
					phase_d = psad_pkg::PH_PAYLOAD;
				end
			end
			psad_pkg::PH_STD: begin
				in_packet = 1'b1;
				phase_d   = psad_pkg::PH_TS;
			end
			psad_pkg::PH_FSKIP: begin
				in_packet = 1'b1;
				if (field_skip_q != 4'd0) field_skip_d = field_skip_q - 4'd1;
				if (field_skip_q <= 4'd1) phase_d = psad_pkg::PH_PAYLOAD;
			end
			psad_pkg::PH_PAYLOAD: begin
				in_packet = 1'b1;
			end
			default: begin
				phase_d = psad_pkg::PH_ENDED;
			end
		endcase

		// The packet length bounds every skip inside the packet.
		if (in_packet) begin
			if (remaining_q != 16'd0) remaining_d = remaining_q - 16'd1;
			if (remaining_q <= 16'd1) begin
				zero_run_d = 2'd0;
				phase_d    = psad_pkg::PH_SEARCH;
			end
		end

		// The final byte returns the parser to its reset state.
		if (end_of_input) begin
			phase_d        = psad_pkg::PH_SEARCH;
			zero_run_d     = 2'd0;
			header_count_d = 4'd0;
			length_high_d  = 8'd0;
			remaining_d    = 16'd0;
			field_skip_d   = 4'd0;
			locked_id_d    = 8'd0;
			id_locked_d    = 1'b0;
		end
	end

	// Outputs.
	always_comb begin
		case (phase_q)
			psad_pkg::PH_PAYLOAD: emit = 1'b1;
			psad_pkg::PH_STUFF:   emit = in_byte != psad_pkg::STUFF_BYTE &&
			                             (in_byte & psad_pkg::STD_MASK) != psad_pkg::STD_TAG &&
			                             (in_byte & psad_pkg::TS_MASK) != psad_pkg::TS_PTS &&
			                             (in_byte & psad_pkg::TS_MASK) != psad_pkg::TS_PTS_DTS &&
			                             in_byte != psad_pkg::TS_NONE;
			psad_pkg::PH_TS:      emit = (in_byte & psad_pkg::TS_MASK) != psad_pkg::TS_PTS &&
			                             (in_byte & psad_pkg::TS_MASK) != psad_pkg::TS_PTS_DTS &&
			                             in_byte != psad_pkg::TS_NONE;
			default:              emit = 1'b0;
		endcase

		push                   = accept && (emit || end_of_input);
		result.es_byte         = emit ? in_byte : 8'd0;
		result.byte_valid      = emit;
		result.end_of_stream   = end_of_input;
		// The id locks on the low length byte of the first audio packet.
		result.audio_stream_id = (id_locked_q || phase_q == psad_pkg::PH_LLO_A) ?
		                         locked_id_q : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= psad_pkg::PH_SEARCH;
			zero_run_q     <= 2'd0;
			header_count_q <= 4'd0;
			length_high_q  <= 8'd0;
			remaining_q    <= 16'd0;
			field_skip_q   <= 4'd0;
			locked_id_q    <= 8'd0;
			id_locked_q    <= 1'b0;
		end else if (accept) begin
			phase_q        <= phase_d;
			zero_run_q     <= zero_run_d;
			header_count_q <= header_count_d;
			length_high_q  <= length_high_d;
			remaining_q    <= remaining_d;
			field_skip_q   <= field_skip_d;
			locked_id_q    <= locked_id_d;
			id_locked_q    <= id_locked_d;
		end
	end

endmodule
`default_nettype wire

[sv/psad_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Program stream audio demux: result queue
// Small register queue between the parser and the output channel; its head
// drives the output beat.
// ----------------------------------------------------------------------------
module psad_queue #(
	parameter int Depth = psad_pkg::QUEUE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire psad_pkg::result_t push_data,
	output logic                   full,
	output logic                   head_valid,
	input  wire logic              pop,
	output psad_pkg::result_t      head
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW = $clog2(Depth + 1);

	psad_pkg::result_t entry_q [Depth];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_pop;

	assign full       = count_q == CntW'(Depth);
	assign head_valid = count_q != '0;
	assign head       = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire
